// ===== hdl/cwsf_pkg.sv =====
// cwsf_pkg: shared constants, types and the exponential step table for the
// circular wall force unit. No dependencies.
package cwsf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TAG_WIDTH = 16;
  localparam int POS_W     = 32;
  localparam int REG_W     = 31;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;
  localparam int ROOT_W    = 32;
  localparam int DMAG_W    = 33;
  localparam int FIFO_DEPTH = 4;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WALL_RADIUS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_LENGTH = CFG_IDX_W'(2);

  localparam logic [REG_W-1:0] WALL_RADIUS_RST  = REG_W'(100 << FRAC_BITS);
  localparam logic [REG_W-1:0] STIFFNESS_RST    = REG_W'(1 << FRAC_BITS);
  localparam logic [REG_W-1:0] DECAY_LENGTH_RST = REG_W'(1 << FRAC_BITS);

  // fault codes
  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_ZERO = 2'd1;
  localparam logic [1:0] FAULT_SAT  = 2'd2;

  // round(2^30 * exp(-2^(k-24)))
  function automatic logic [29:0] exp_tab(input logic [4:0] k);
    logic [29:0] v;
    case (k)
      5'd0:  v = 30'd1073741760;
      5'd1:  v = 30'd1073741696;
      5'd2:  v = 30'd1073741568;
      5'd3:  v = 30'd1073741312;
      5'd4:  v = 30'd1073740800;
      5'd5:  v = 30'd1073739776;
      5'd6:  v = 30'd1073737728;
      5'd7:  v = 30'd1073733632;
      5'd8:  v = 30'd1073725440;
      5'd9:  v = 30'd1073709056;
      5'd10: v = 30'd1073676290;
      5'd11: v = 30'd1073610760;
      5'd12: v = 30'd1073479712;
      5'd13: v = 30'd1073217664;
      5'd14: v = 30'd1072693760;
      5'd15: v = 30'd1071646719;
      5'd16: v = 30'd1069555701;
      5'd17: v = 30'd1065385899;
      5'd18: v = 30'd1057095000;
      5'd19: v = 30'd1040706261;
      5'd20: v = 30'd1008687096;
      5'd21: v = 30'd947573834;
      5'd22: v = 30'd836230972;
      5'd23: v = 30'd651257337;
      5'd24: v = 30'd395007542;
      5'd25: v = 30'd145315154;
      5'd26: v = 30'd19666268;
      5'd27: v = 30'd360200;
      5'd28: v = 30'd121;
      default: v = '0;
    endcase
    return v;
  endfunction

  // classified particle handed from the front end to the force pipeline
  typedef struct packed {
    logic [TAG_WIDTH-1:0]    tag;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [ROOT_W-1:0]       root_dist;
    logic                    zero;
    logic                    in_zone;
    logic [DMAG_W-1:0]       d_mag;
  } front_item_t;

endpackage

// ===== hdl/cwsf_if.sv =====
// cwsf_if: valid/ready channel interfaces for particles, forces and
// configuration writes. Depends on cwsf_pkg.
interface cwsf_in_if import cwsf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [TAG_WIDTH-1:0]    particle_index;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [REG_W-1:0]        particle_radius;
  modport source (output valid, particle_index, pos_x, pos_y, particle_radius,
                  input ready);
  modport sink (input valid, particle_index, pos_x, pos_y, particle_radius,
                output ready);
endinterface

interface cwsf_out_if import cwsf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [TAG_WIDTH-1:0]    tag_out;
  logic signed [POS_W-1:0] force_x;
  logic signed [POS_W-1:0] force_y;
  logic                    inside_zone;
  logic [1:0]              fault;
  modport source (output valid, tag_out, force_x, force_y, inside_zone, fault,
                  input ready);
  modport sink (input valid, tag_out, force_x, force_y, inside_zone, fault,
                output ready);
endinterface

interface cwsf_cfg_if import cwsf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/circular_wall_soft_force_unit.sv =====
// circular_wall_soft_force_unit: top level with the configuration registers,
// front end, queue and force pipeline.
// Depends on cwsf_pkg, cwsf_if, cwsf_front, cwsf_fifo, cwsf_back.
//
// Usage:
//   in_ch  takes one particle (tag, x, y, radius) per valid/ready request.
//   out_ch returns one force result per particle, in order.
//   cfg_ch writes wall_radius (0), stiffness (1), decay_length (2); it is
//   always ready, writes to other indexes are dropped. Write only while idle.
// Throughput: one particle per cycle while out_ch is ready.
// Pipeline: the request passes 36 front registers (squares, 32-stage square
//   root, classify), the first taken at the accepting edge, one queue slot and
//   55 force stages (a 50-stage quotient divider sets the length; the 21-stage
//   divider and 21-stage exponential chain run beside it).
// Reset: all pipelines empty, registers at 100.0, 1.0 and 1.0.
// Stalls: a result waiting on out_ch holds the force pipeline; the front end
//   accepts until the 4-entry queue and its last stage fill, then in_ch ready drops.
module circular_wall_soft_force_unit import cwsf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  cwsf_in_if.sink    in_ch,
  cwsf_out_if.source out_ch,
  cwsf_cfg_if.sink   cfg_ch
);

  logic [REG_W-1:0] wall_radius_r, stiffness_r, decay_length_r;
  logic             f_valid, f_ready, b_valid, b_ready;
  front_item_t      f_item, b_item;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_radius_r  <= WALL_RADIUS_RST;
      stiffness_r    <= STIFFNESS_RST;
      decay_length_r <= DECAY_LENGTH_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_WALL_RADIUS:  wall_radius_r  <= cfg_ch.data[REG_W-1:0];
        REG_STIFFNESS:    stiffness_r    <= cfg_ch.data[REG_W-1:0];
        REG_DECAY_LENGTH: decay_length_r <= cfg_ch.data[REG_W-1:0];
        default: ;
      endcase
    end
  end

  cwsf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .wall_radius (wall_radius_r),
    .item_valid  (f_valid),
    .item_ready  (f_ready),
    .item        (f_item)
  );

  cwsf_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  cwsf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (b_valid),
    .item_ready   (b_ready),
    .item         (b_item),
    .stiffness    (stiffness_r),
    .decay_length (decay_length_r),
    .out_ch       (out_ch)
  );

endmodule

// ===== hdl/cwsf_front.sv =====
// cwsf_front: accepts particles, computes the integer distance with a
// pipelined square root and classifies inside/outside. Depends on cwsf_pkg, cwsf_if.
module cwsf_front import cwsf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  cwsf_in_if.sink          in_ch,
  input  logic [REG_W-1:0] wall_radius,
  output logic             item_valid,
  input  logic             item_ready,
  output front_item_t      item
);

  // stage 0 input, 1 squares, 2 sum, then one root bit per stage, last item
  localparam int NF  = ROOT_W + 4;
  localparam int RW  = 2 * ROOT_W + 2;
  localparam int SQW = 2 * POS_W;

  typedef struct packed {
    logic [TAG_WIDTH-1:0]    tag;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [REG_W-1:0]        prad;
  } carry_t;

  logic              en;
  logic [NF-1:0]     vld_r;
  carry_t            carry_r [0:NF-2];
  logic [SQW-1:0]    sqx_r, sqy_r;
  logic [RW-1:0]     rem_r  [2:NF-2];
  logic [ROOT_W-1:0] root_r [2:NF-2];
  logic [POS_W-1:0]  ax, ay;
  logic signed [DMAG_W+1:0] d;
  logic [DMAG_W+1:0] d_neg;
  front_item_t       item_r, item_nxt;

  assign en           = !vld_r[NF-1] || item_ready;
  assign in_ch.ready  = en;
  assign item_valid   = vld_r[NF-1];
  assign item         = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NF-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      carry_r[0] <= '{in_ch.particle_index, in_ch.pos_x, in_ch.pos_y,
                      in_ch.particle_radius};
      for (int k = 1; k < NF - 1; k++) begin
        carry_r[k] <= carry_r[k-1];
      end
    end
  end

  assign ax = carry_r[0].x[POS_W-1] ? POS_W'(-carry_r[0].x) : POS_W'(carry_r[0].x);
  assign ay = carry_r[0].y[POS_W-1] ? POS_W'(-carry_r[0].y) : POS_W'(carry_r[0].y);

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r     <= SQW'(ax) * SQW'(ax);
      sqy_r     <= SQW'(ay) * SQW'(ay);
      rem_r[2]  <= RW'(sqx_r) + RW'(sqy_r);
      root_r[2] <= '0;
    end
  end

  // restoring square root, one result bit per stage, msb first
  for (genvar s = 3; s <= NF - 2; s++) begin : g_sqrt
    localparam int I = NF - 2 - s;
    logic [RW-1:0] trial;
    logic          take;
    assign trial = (RW'(root_r[s-1]) << (I + 1)) + (RW'(1) << (2 * I));
    assign take  = rem_r[s-1] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= take ? rem_r[s-1] - trial : rem_r[s-1];
        root_r[s] <= take ? (root_r[s-1] | (ROOT_W'(1) << I)) : root_r[s-1];
      end
    end
  end

  // d = r + particle_radius - wall_radius
  assign d = $signed((DMAG_W+2)'(root_r[NF-2])) + $signed((DMAG_W+2)'(carry_r[NF-2].prad))
           - $signed((DMAG_W+2)'(wall_radius));
  assign d_neg = -d;

  always_comb begin
    item_nxt.tag       = carry_r[NF-2].tag;
    item_nxt.pos_x     = carry_r[NF-2].x;
    item_nxt.pos_y     = carry_r[NF-2].y;
    item_nxt.root_dist = root_r[NF-2];
    item_nxt.zero      = root_r[NF-2] == '0;
    item_nxt.in_zone   = d[DMAG_W+1];
    item_nxt.d_mag     = d[DMAG_W+1] ? d_neg[DMAG_W-1:0] : d[DMAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== hdl/cwsf_fifo.sv =====
// cwsf_fifo: short queue of classified particles between front end and
// force pipeline. Depends on cwsf_pkg.
module cwsf_fifo import cwsf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  front_item_t push_item,
  output logic        pop_valid,
  input  logic        pop_ready,
  output front_item_t pop_item
);

  localparam int PW = $clog2(FIFO_DEPTH);

  front_item_t       mem_r [0:FIFO_DEPTH-1];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [PW:0]       count_r;
  logic              push, pop;

  assign push_ready = count_r != (PW+1)'(FIFO_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      if (push && !pop)      count_r <= count_r + (PW+1)'(1);
      else if (pop && !push) count_r <= count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/cwsf_back.sv =====
// cwsf_back: force pipeline: spring magnitude, pipelined dividers, the
// exponential softening chain, saturation and the output register. Depends on cwsf_pkg, cwsf_if.
module cwsf_back import cwsf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             item_ready,
  input  front_item_t      item,
  input  logic [REG_W-1:0] stiffness,
  input  logic [REG_W-1:0] decay_length,
  cwsf_out_if.source       out_ch
);

  localparam int T_BITS     = FRAC_BITS + 5;
  localparam int Q_BITS     = 50;
  localparam int TDIV_FIRST = 1;
  localparam int DIV_FIRST  = 3;
  localparam int EXP_FIRST  = TDIV_FIRST + T_BITS;
  localparam int SCALE_STEP = DIV_FIRST + Q_BITS;
  localparam int NB         = SCALE_STEP + 2;
  localparam int DEN_W      = ROOT_W + FRAC_BITS - 1;
  localparam int REMW       = 97;
  localparam int TREMW      = 32 + FRAC_BITS;
  localparam int TCW        = REG_W + T_BITS;
  localparam int EW         = FRAC_BITS + 1;
  localparam int MW         = Q_BITS + 1;

  typedef struct packed {
    logic [TAG_WIDTH-1:0] tag;
    logic                 zero;
    logic                 in_zone;
    logic                 xneg;
    logic                 yneg;
    logic [POS_W-1:0]     cmx;
    logic [POS_W-1:0]     cmy;
    logic [DEN_W-1:0]     den;
    logic [63:0]          ad;
    logic [63:0]          plx;
    logic [63:0]          phx;
    logic [63:0]          ply;
    logic [63:0]          phy;
    logic [REMW-1:0]      remx;
    logic [REMW-1:0]      remy;
    logic [Q_BITS-1:0]    qx;
    logic [Q_BITS-1:0]    qy;
    logic [TREMW-1:0]     trem;
    logic [T_BITS-1:0]    t;
    logic                 ovf;
    logic [30:0]          acc;
  } bst_t;

  logic              en;
  logic [NB-1:0]     vld_r;
  bst_t              st_r [0:NB-2];
  bst_t              s0_nxt;
  logic [REG_W-1:0]  dlen;
  logic [MW-1:0]     mx, my;
  logic [32:0]       fxs, fys;
  logic [TAG_WIDTH-1:0]    tag_r;
  logic signed [POS_W-1:0] fx_r, fy_r;
  logic                    inside_r;
  logic [1:0]              fault_r;

  assign en          = !vld_r[NB-1] || out_ch.ready;
  assign item_ready  = en;
  assign dlen        = (decay_length == '0) ? REG_W'(1) : decay_length;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NB-2:0], item_valid};
    end
  end

  // spring magnitude |d|*stiffness and the setup of both dividers
  always_comb begin
    s0_nxt         = '0;
    s0_nxt.tag     = item.tag;
    s0_nxt.zero    = item.zero;
    s0_nxt.in_zone = item.in_zone;
    s0_nxt.xneg    = item.pos_x[POS_W-1];
    s0_nxt.yneg    = item.pos_y[POS_W-1];
    s0_nxt.cmx     = item.pos_x[POS_W-1] ? POS_W'(-item.pos_x) : POS_W'(item.pos_x);
    s0_nxt.cmy     = item.pos_y[POS_W-1] ? POS_W'(-item.pos_y) : POS_W'(item.pos_y);
    s0_nxt.den     = {item.root_dist, (FRAC_BITS-1)'(0)};
    s0_nxt.ad      = 64'(64'(item.d_mag) * 64'(stiffness));
    s0_nxt.trem    = {item.d_mag[31:0], FRAC_BITS'(0)};
    s0_nxt.ovf     = (REG_W+5)'(item.d_mag) >= {dlen, 5'd0};
    s0_nxt.acc     = 31'(1) << 30;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= s0_nxt;
    end
  end

  for (genvar j = 1; j < NB - 1; j++) begin : g_step
    localparam bit IS_TDIV = (j >= TDIV_FIRST) && (j < TDIV_FIRST + T_BITS);
    localparam bit IS_EXP  = (j >= EXP_FIRST) && (j < EXP_FIRST + T_BITS);
    localparam bit IS_DIV  = (j >= DIV_FIRST) && (j < DIV_FIRST + Q_BITS);
    localparam int TK = IS_TDIV ? (TDIV_FIRST + T_BITS - 1 - j) : 0;
    localparam int EB = IS_EXP ? (j - EXP_FIRST) : 0;
    localparam int DK = IS_DIV ? (DIV_FIRST + Q_BITS - 1 - j) : 0;
    localparam logic [29:0] EXP_T = exp_tab(5'(EB + 24 - FRAC_BITS));
    bst_t             prv, nxt;
    logic [TCW-1:0]   tcand;
    logic [REMW-1:0]  dcand;
    logic [EW-1:0]    e;

    assign prv   = st_r[j-1];
    assign tcand = TCW'(dlen) << TK;
    assign dcand = REMW'(prv.den) << DK;
    assign e     = prv.ovf ? '0 : EW'(prv.acc >> (30 - FRAC_BITS));

    always_comb begin
      nxt = prv;
      if (j == 1) begin
        nxt.plx = 64'(64'(prv.ad[31:0]) * 64'(prv.cmx));
        nxt.phx = 64'(64'(prv.ad[63:32]) * 64'(prv.cmx));
        nxt.ply = 64'(64'(prv.ad[31:0]) * 64'(prv.cmy));
        nxt.phy = 64'(64'(prv.ad[63:32]) * 64'(prv.cmy));
      end
      if (j == 2) begin
        nxt.remx = REMW'({prv.phx, 32'd0}) + REMW'(prv.plx);
        nxt.remy = REMW'({prv.phy, 32'd0}) + REMW'(prv.ply);
      end
      if (IS_TDIV) begin
        if (TCW'(prv.trem) >= tcand) begin
          nxt.trem  = TREMW'(TCW'(prv.trem) - tcand);
          nxt.t[TK] = 1'b1;
        end
      end
      if (IS_EXP) begin
        if (prv.t[EB]) begin
          nxt.acc = 31'((62'(prv.acc) * 62'(EXP_T)) >> 30);
        end
      end
      if (IS_DIV) begin
        if (prv.remx >= dcand) begin
          nxt.remx   = prv.remx - dcand;
          nxt.qx[DK] = 1'b1;
        end
        if (prv.remy >= dcand) begin
          nxt.remy   = prv.remy - dcand;
          nxt.qy[DK] = 1'b1;
        end
      end
      // partial products of quotient times softening factor
      if (j == SCALE_STEP) begin
        nxt.plx = 64'(64'(prv.qx[31:0]) * 64'(e));
        nxt.phx = 64'(64'(prv.qx[Q_BITS-1:32]) * 64'(e));
        nxt.ply = 64'(64'(prv.qy[31:0]) * 64'(e));
        nxt.phy = 64'(64'(prv.qy[Q_BITS-1:32]) * 64'(e));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j] <= nxt;
      end
    end
  end

  // {saturated, value}
  function automatic logic [32:0] sat_force(input logic [MW-1:0] m, input logic neg);
    logic [32:0] r;
    if (m == '0) begin
      r = '0;
    end else if (neg) begin
      if (m > MW'(33'h0_8000_0000)) r = {1'b1, 32'h8000_0000};
      else                          r = {1'b0, 32'(-m)};
    end else begin
      if (m > MW'(32'h7FFF_FFFF)) r = {1'b1, 32'h7FFF_FFFF};
      else                        r = {1'b0, m[31:0]};
    end
    return r;
  endfunction

  assign mx = st_r[NB-2].in_zone
            ? MW'((67'({st_r[NB-2].phx[34:0], 32'd0}) + 67'(st_r[NB-2].plx[48:0]))
                  >> FRAC_BITS)
            : MW'(st_r[NB-2].qx);
  assign my = st_r[NB-2].in_zone
            ? MW'((67'({st_r[NB-2].phy[34:0], 32'd0}) + 67'(st_r[NB-2].ply[48:0]))
                  >> FRAC_BITS)
            : MW'(st_r[NB-2].qy);
  assign fxs = sat_force(mx, st_r[NB-2].in_zone == st_r[NB-2].xneg);
  assign fys = sat_force(my, st_r[NB-2].in_zone == st_r[NB-2].yneg);

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r <= st_r[NB-2].tag;
      if (st_r[NB-2].zero) begin
        fx_r     <= '0;
        fy_r     <= '0;
        inside_r <= 1'b0;
        fault_r  <= FAULT_ZERO;
      end else begin
        fx_r     <= fxs[31:0];
        fy_r     <= fys[31:0];
        inside_r <= st_r[NB-2].in_zone;
        fault_r  <= (fxs[32] || fys[32]) ? FAULT_SAT : FAULT_NONE;
      end
    end
  end

  assign out_ch.valid       = vld_r[NB-1];
  assign out_ch.tag_out     = tag_r;
  assign out_ch.force_x     = fx_r;
  assign out_ch.force_y     = fy_r;
  assign out_ch.inside_zone = inside_r;
  assign out_ch.fault       = fault_r;

endmodule

// ===== sim/circular_wall_soft_force_unit_tb.sv =====
// circular_wall_soft_force_unit_tb: drives particles through the circular wall force unit,
// predicts each force result and checks it field by field, across several register settings.
// Depends on cwsf_pkg, cwsf_if and the circular_wall_soft_force_unit RTL.
module circular_wall_soft_force_unit_tb;
  import cwsf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);
  localparam logic [63:0] SAT_NEG = 64'h8000_0000;
  localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF;
  localparam int PHASE_ITEMS = 330;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [TAG_WIDTH-1:0]    tag;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [REG_W-1:0]        radius;
  } particle_t;

  typedef struct packed {
    logic [TAG_WIDTH-1:0]    tag;
    logic signed [POS_W-1:0] force_x;
    logic signed [POS_W-1:0] force_y;
    logic                    in_zone;
    logic [1:0]              fault;
  } wall_force_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cwsf_in_if  in_ch();
  cwsf_out_if out_ch();
  cwsf_cfg_if cfg_ch();

  circular_wall_soft_force_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [REG_W-1:0] wall_r  = WALL_RADIUS_RST;
  logic [REG_W-1:0] stiff   = STIFFNESS_RST;
  logic [REG_W-1:0] decay   = DECAY_LENGTH_RST;

  particle_t   particle_q[$];
  wall_force_t force_q[$];
  int send_idle = 19;
  int recv_idle = 56;
  int errors = 0;
  int checked = 0;
  int n_inside = 0;
  int n_zero = 0;
  int n_sat = 0;

  // round(2^30 * exp(-2^(b-16))) for fraction bit b = 0..20
  logic [63:0] exp_steps[21] = '{
    64'd1073725440, 64'd1073709056, 64'd1073676290, 64'd1073610760,
    64'd1073479712, 64'd1073217664, 64'd1072693760, 64'd1071646719,
    64'd1069555701, 64'd1065385899, 64'd1057095000, 64'd1040706261,
    64'd1008687096, 64'd947573834,  64'd836230972,  64'd651257337,
    64'd395007542,  64'd145315154,  64'd19666268,   64'd360200,
    64'd121
  };

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] decay_scale(logic [63:0] t);
    logic [63:0] acc;
    if ((t >> 16) >= 32) return 0;
    acc = 64'd1 << 30;
    for (int b = 0; b <= 20; b++)
      if (t[b]) acc = (acc * exp_steps[b]) >> 30;
    return acc >> 14;
  endfunction

  function automatic logic [31:0] force_axis(logic [63:0] ad, logic in_zone, longint c,
                                             logic [63:0] r, logic [63:0] e, ref bit sat);
    logic [127:0] prod, quo;
    logic [63:0] cm, m;
    bit neg;
    cm = (c < 0) ? 64'(-c) : 64'(c);
    prod = {64'b0, ad} * {64'b0, cm};
    quo = prod / ({64'b0, r} << 15);
    m = quo[63:0];
    if (in_zone) begin
      prod = {64'b0, m} * {64'b0, e};
      m = prod[79:16];
    end
    if (m == 0) return 0;
    neg = (in_zone == (c < 0));
    if (neg) begin
      if (m > SAT_NEG) begin sat = 1; m = SAT_NEG; end
      return 32'(-m);
    end
    if (m > SAT_POS) begin sat = 1; m = SAT_POS; end
    return m[31:0];
  endfunction

  function automatic wall_force_t wall_force(particle_t p);
    longint x, y, d;
    logic [63:0] ax, ay, r, ad, e, len, t;
    bit sat;
    wall_force_t f;
    x = p.pos_x;
    y = p.pos_y;
    ax = (x < 0) ? 64'(-x) : 64'(x);
    ay = (y < 0) ? 64'(-y) : 64'(y);
    r = int_sqrt(ax * ax + ay * ay);
    sat = 0;
    e = 0;
    f = '0;
    f.tag = p.tag;
    if (r == 0) begin
      f.fault = FAULT_ZERO;
      return f;
    end
    d = longint'(r) + longint'({33'b0, p.radius}) - longint'({33'b0, wall_r});
    f.in_zone = (d < 0);
    ad = 64'(f.in_zone ? -d : d) * {33'b0, stiff};
    if (f.in_zone) begin
      len = (decay == 0) ? 64'd1 : {33'b0, decay};
      t = (64'(-d) << 16) / len;
      e = decay_scale(t);
    end
    f.force_x = force_axis(ad, f.in_zone, x, r, e, sat);
    f.force_y = force_axis(ad, f.in_zone, y, r, e, sat);
    f.fault = sat ? FAULT_SAT : FAULT_NONE;
    return f;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        force_q.push_back(wall_force({in_ch.particle_index, in_ch.pos_x, in_ch.pos_y,
                                      in_ch.particle_radius}));
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (particle_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          particle_t p;
          p = particle_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.particle_index <= p.tag;
          in_ch.pos_x <= p.pos_x;
          in_ch.pos_y <= p.pos_y;
          in_ch.particle_radius <= p.radius;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
      if (out_ch.valid && out_ch.ready) begin
        if (force_q.size() == 0) begin
          $error("result with tag %0h arrived with nothing outstanding", out_ch.tag_out);
          errors++;
        end else begin
          wall_force_t w;
          w = force_q.pop_front();
          checked++;
          if (w.in_zone) n_inside++;
          if (w.fault == FAULT_ZERO) n_zero++;
          if (w.fault == FAULT_SAT) n_sat++;
          if (out_ch.tag_out !== w.tag) begin
            $error("tag_out expected %0h got %0h", w.tag, out_ch.tag_out); errors++;
          end
          if (out_ch.force_x !== w.force_x) begin
            $error("force_x expected %0d got %0d", w.force_x, out_ch.force_x); errors++;
          end
          if (out_ch.force_y !== w.force_y) begin
            $error("force_y expected %0d got %0d", w.force_y, out_ch.force_y); errors++;
          end
          if (out_ch.inside_zone !== w.in_zone) begin
            $error("inside_zone expected %0b got %0b", w.in_zone, out_ch.inside_zone);
            errors++;
          end
          if (out_ch.fault !== w.fault) begin
            $error("fault expected %0d got %0d", w.fault, out_ch.fault); errors++;
          end
        end
      end
    end
  end

  task automatic add_particle(logic [15:0] tag, logic [31:0] x, logic [31:0] y,
                              logic [30:0] rad);
    particle_q.push_back({tag, x, y, rad});
  endtask

  // sampled away from the rising edge so driver and monitor updates have settled
  task automatic wait_drained();
    while (particle_q.size() != 0 || in_ch.valid || force_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_WALL_RADIUS:  wall_r = val[30:0];
      REG_STIFFNESS:    stiff = val[30:0];
      REG_DECAY_LENGTH: decay = val[30:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] signed_upto(logic [63:0] lim);
    logic [63:0] mag;
    mag = {32'b0, $urandom_range(32'(lim), 0)};
    return $urandom_range(1) ? 32'(-mag) : mag[31:0];
  endfunction

  task automatic add_random_particle();
    logic [63:0] lim;
    logic [31:0] x, y;
    logic [30:0] rad;
    lim = {33'b0, wall_r} * 2 + 64'd65536;
    if (lim > SAT_POS) lim = SAT_POS;
    case ($urandom_range(4))
      0: begin x = $urandom; y = $urandom; end
      1, 2: begin x = signed_upto(lim); y = signed_upto(lim); end
      3: begin x = signed_upto(64'd2000); y = signed_upto(64'd2000); end
      default: begin
        x = signed_upto(lim); y = 0;
        if ($urandom_range(1)) begin y = x; x = 0; end
      end
    endcase
    case ($urandom_range(3))
      0: rad = 31'($urandom);
      1: rad = 31'($urandom_range(4 << 16));
      default: rad = 31'($urandom_range(32'(wall_r)));
    endcase
    add_particle(16'($urandom), x, y, rad);
  endtask

  initial begin
    static logic [30:0] set_wall[6] = '{31'd6553600, 31'h7FFFFFFF, 31'd0, 31'd65536000,
                                        31'h40000000, 31'd3276800};
    static logic [30:0] set_stiff[6] = '{31'd65536, 31'h7FFFFFFF, 31'd0, 31'd16384,
                                         31'd196608, 31'd6553600};
    static logic [30:0] set_decay[6] = '{31'd65536, 31'h7FFFFFFF, 31'd0, 31'd524288,
                                         31'd1, 31'd32768};
    in_ch.valid = 1'b0;
    in_ch.particle_index = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.particle_radius = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners at reset settings
    add_particle(16'h0000, 32'd0, 32'd0, 31'd0);
    add_particle(16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF);
    add_particle(16'h1234, 32'h80000000, 32'h80000000, 31'd0);
    add_particle(16'h8000, 32'h80000000, 32'd0, 31'h7FFFFFFF);
    add_particle(16'h0001, 32'd0, 32'h7FFFFFFF, 31'd65536);
    add_particle(16'h00AA, 32'(10 << 16), 32'd0, 31'(1 << 16));
    add_particle(16'h5555, 32'(99 << 16), 32'd0, 31'd0);
    add_particle(16'hAAAA, 32'(3 << 16), -32'(4 << 16), 31'(94 << 16) + 31'd32768);
    add_particle(16'h0F0F, 32'(60 << 16), 32'(80 << 16), 31'd0);
    add_particle(16'hF0F0, -32'(70 << 16), 32'(80 << 16), 31'(5 << 16));
    add_particle(16'h0002, 32'd1, 32'd0, 31'd0);
    add_particle(16'h0003, 32'd0, 32'hFFFFFFFF, 31'h7FFFFFFF);
    add_particle(16'h0004, 32'(99 << 16), 32'd0, 31'(1 << 16) - 31'd1);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        write_reg(REG_WALL_RADIUS, {1'b0, set_wall[ph]});
        write_reg(REG_STIFFNESS, {1'b0, set_stiff[ph]});
        write_reg(REG_DECAY_LENGTH, {1'b0, set_decay[ph]});
        if (ph == 3) write_reg(REG_UNUSED, 32'hFFFFFFFF);
      end
      case (ph % 3)
        0: begin send_idle = 19; recv_idle = 56; end
        1: begin send_idle = 56; recv_idle = 19; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) add_random_particle();
      // sender holds off here until every outstanding result is back
      wait_drained();
    end

    $display("checked %0d force results over 6 wall settings", checked);
    $display("inside zone %0d, zero distance %0d, saturated %0d", n_inside, n_zero, n_sat);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", force_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
